@@ rtl/core/rtfx_pkg.sv @@
package rtfx_pkg;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'd0,
    MODE_ESC    = 4'd1,
    MODE_HEX1   = 4'd2,
    MODE_HEX2   = 4'd3,
    MODE_WORD   = 4'd4,
    MODE_DIGITS = 4'd5,
    MODE_NEG    = 4'd6
  } mode_t;

  localparam int MAX_EMIT = 3;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW = 2;

  localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
  localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;
  localparam logic signed [4:0]  LIMIT_RESET = 5'sd1;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;

  // results of one byte, oldest in slot 0
  typedef struct packed {
    logic [1:0]          cnt;
    logic [2:0][7:0]     bytes;
  } emit_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (is_digit(b)) v = b - 8'h30;
    else if (b >= 8'h61) v = b - 8'h57;
    else v = b - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic [7:0] par_ch(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_P;
      2'd1:    c = CH_A;
      default: c = CH_R;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tab_ch(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CH_T;
      2'd1:    c = CH_A;
      default: c = CH_B;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/rtfx_parser.sv @@
module rtfx_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           in_byte,
  input  logic                 in_end_of_doc,
  input  logic signed [4:0]    depth_limit,
  output rtfx_pkg::emit_t      emit
);
  import rtfx_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic signed [15:0] depth_r, depth_nxt;
  logic [7:0]        hex_r, hex_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              par_r, par_nxt;
  logic              tab_r, tab_nxt;

  logic              en;
  logic              do_plain;
  logic              do_tail;
  logic [1:0]        n;
  logic [2:0][7:0]   bytes;

  assign en = depth_r <= $signed({{11{depth_limit[4]}}, depth_limit});

  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    hex_nxt   = hex_r;
    cnt_nxt   = cnt_r;
    par_nxt   = par_r;
    tab_nxt   = tab_r;
    do_plain  = 1'b0;
    do_tail   = 1'b0;
    n         = 2'd0;
    bytes     = '0;

    case (mode_r)
      MODE_ESC: begin
        if (in_byte == CH_QUOTE) begin
          mode_nxt = MODE_HEX1;
        end else if (is_alpha(in_byte)) begin
          mode_nxt = MODE_WORD;
          cnt_nxt  = 2'd1;
          par_nxt  = in_byte == CH_P;
          tab_nxt  = in_byte == CH_T;
        end else begin
          do_tail = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_alpha(in_byte)) begin
          if (cnt_r != 2'd3) begin
            par_nxt = par_r && in_byte == par_ch(cnt_r);
            tab_nxt = tab_r && in_byte == tab_ch(cnt_r);
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            par_nxt = 1'b0;
            tab_nxt = 1'b0;
          end
        end else if (cnt_r == 2'd3 && (par_r || tab_r)) begin
          if (en) begin
            if (par_r) begin
              bytes[0] = CH_CR;
              bytes[1] = CH_LF;
              n = 2'd2;
            end else begin
              bytes[0] = CH_TAB;
              n = 2'd1;
            end
          end
          mode_nxt = MODE_NORMAL;
          do_plain = in_byte != CH_SPACE;
        end else begin
          do_tail = 1'b1;
        end
      end
      MODE_DIGITS: begin
        do_tail = !is_digit(in_byte);
      end
      MODE_NEG: begin
        if (is_digit(in_byte)) begin
          mode_nxt = MODE_NEG;
        end else if (in_byte == CH_SPACE) begin
          mode_nxt = MODE_NORMAL;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_HEX1: begin
        if (is_hex(in_byte)) begin
          hex_nxt  = in_byte;
          mode_nxt = MODE_HEX2;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_HEX2: begin
        if (is_hex(in_byte)) begin
          if (en) begin
            bytes[0] = {hex_val(hex_r), hex_val(in_byte)};
            n = 2'd1;
          end
          mode_nxt = MODE_NORMAL;
        end else begin
          if (en) begin
            bytes[0] = hex_r;
            n = 2'd1;
          end
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // control word tail: digits, optional minus part, one space
    if (do_tail) begin
      if (is_digit(in_byte)) mode_nxt = MODE_DIGITS;
      else if (in_byte == CH_MINUS) mode_nxt = MODE_NEG;
      else if (in_byte == CH_SPACE) mode_nxt = MODE_NORMAL;
      else do_plain = 1'b1;
    end

    if (do_plain) begin
      mode_nxt = MODE_NORMAL;
      if (in_byte == CH_LBRACE) begin
        if (depth_r != DEPTH_MAX) depth_nxt = depth_r + 16'sd1;
      end else if (in_byte == CH_RBRACE) begin
        if (depth_r != DEPTH_MIN) depth_nxt = depth_r - 16'sd1;
      end else if (in_byte == CH_CR || in_byte == CH_LF) begin
        mode_nxt = MODE_NORMAL;
      end else if (in_byte == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else if (en) begin
        bytes[n] = in_byte;
        n = n + 2'd1;
      end
    end

    // end of document: flush what is complete, then back to reset state
    if (in_end_of_doc) begin
      if (en) begin
        if (mode_nxt == MODE_HEX2) begin
          bytes[n] = hex_nxt;
          n = n + 2'd1;
        end else if (mode_nxt == MODE_WORD && cnt_nxt == 2'd3) begin
          if (par_nxt) begin
            bytes[0] = CH_CR;
            bytes[1] = CH_LF;
            n = 2'd2;
          end else if (tab_nxt) begin
            bytes[0] = CH_TAB;
            n = 2'd1;
          end
        end
      end
      mode_nxt  = MODE_NORMAL;
      depth_nxt = '0;
      hex_nxt   = '0;
      cnt_nxt   = '0;
      par_nxt   = 1'b0;
      tab_nxt   = 1'b0;
    end

    emit.cnt   = n;
    emit.bytes = bytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      depth_r <= '0;
      hex_r   <= '0;
      cnt_r   <= '0;
      par_r   <= 1'b0;
      tab_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      hex_r   <= hex_nxt;
      cnt_r   <= cnt_nxt;
      par_r   <= par_nxt;
      tab_r   <= tab_nxt;
    end
  end

  a_eod_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_doc |=> mode_r == MODE_NORMAL && depth_r == 16'sd0 && cnt_r == 2'd0)
    else $error("state not cleared after last byte");

  a_word_has_letter: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_WORD |-> cnt_r != 2'd0)
    else $error("control word mode with no letters");

  a_match_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(par_r && tab_r))
    else $error("par and tab both matching");

endmodule

@@ rtl/core/rtfx_out_fifo.sv @@
module rtfx_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rtfx_pkg::emit_t emit,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_text_byte,
  output logic            out_run_last
);
  import rtfx_pkg::*;

  logic [8:0]        mem_r [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_AW:0]   count_r, count_nxt;
  logic [1:0]        wr_cnt;
  logic              pop;

  assign wr_cnt    = push ? emit.cnt : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = count_r != '0;
  // room for a full set of results from one byte
  assign room      = count_r <= (OUT_AW + 1)'(OUT_DEPTH - MAX_EMIT);

  assign {out_text_byte, out_run_last} = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + OUT_AW'(wr_cnt);
  assign rd_ptr_nxt = rd_ptr_r + OUT_AW'(pop);
  assign count_nxt  = count_r + (OUT_AW + 1)'(wr_cnt) - (OUT_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_EMIT; i++) begin
      if (2'(i) < wr_cnt) begin
        mem_r[wr_ptr_r + OUT_AW'(i)] <= {emit.bytes[i], 2'(i) == wr_cnt - 2'd1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (OUT_AW + 1)'(OUT_DEPTH))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    wr_cnt != 2'd0 |-> count_r + (OUT_AW + 1)'(wr_cnt) <= (OUT_AW + 1)'(OUT_DEPTH))
    else $error("results pushed without room");

endmodule

@@ rtl/core/rtf_plain_text_extractor_unit.sv @@
// a result of an accepted byte is registered in the result queue and offered on out_
// throughput: one byte per cycle while out_ready is high and each byte gives at most
//   one result; a byte with two or three results stalls input, set by the one-wide result
//   port draining a four-entry queue (input is taken while at most one result waits)
// reset (rst_n low, synchronous): parser back to normal text at depth zero,
//   result queue empty, depth limit back to 1
module rtf_plain_text_extractor_unit (
  input  logic              clk,
  input  logic              rst_n,
  // byte input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_doc,
  // text output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_text_byte,
  output logic              out_run_last,
  // depth limit register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic signed [4:0] cfg_text_depth_limit
);
  import rtfx_pkg::*;

  logic signed [4:0] limit_r;
  logic              accept;
  logic              room;
  emit_t             emit;

  // config writes land at any time; the user must write it only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_text_depth_limit;
    end
  end

  // a byte is taken whenever its worst-case results fit in the queue
  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  // per-byte state machine, decides all results of a byte combinationally
  rtfx_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_end_of_doc (in_end_of_doc),
    .depth_limit   (limit_r),
    .emit          (emit)
  );

  // result queue, separates the two sides and serializes multi-byte results
  rtfx_out_fifo u_out_fifo (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (accept),
    .emit          (emit),
    .room          (room),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_byte (out_text_byte),
    .out_run_last  (out_run_last)
  );

endmodule
